>>> rtl/md5spd_pkg.sv
`timescale 1ns / 1ps

package md5spd_pkg;

    // one input item: message words 0 to 13, two per field
    typedef struct packed {
        logic [63:0] block_words_12_13;
        logic [63:0] block_words_10_11;
        logic [63:0] block_words_8_9;
        logic [63:0] block_words_6_7;
        logic [63:0] block_words_4_5;
        logic [63:0] block_words_2_3;
        logic [63:0] block_words_0_1;
    } t_in_item;

    // one result item: the four digest words
    typedef struct packed {
        logic [63:0] digest_cd;
        logic [63:0] digest_ab;
    } t_out_item;

    // working variables carried down the chain
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_state;

    // sixteen message words, word 0 at index 0
    typedef logic [15:0][31:0] t_msg;

    localparam int NUM_STEPS = 64;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [1:0] RND_F = 2'd0;
    localparam logic [1:0] RND_G = 2'd1;
    localparam logic [1:0] RND_H = 2'd2;
    localparam logic [1:0] RND_I = 2'd3;

    localparam logic [63:0][31:0] STEP_K = {
        32'heb86d391, 32'h2ad7d2bb, 32'hbd3af235, 32'hf7537e82,
        32'h4e0811a1, 32'ha3014314, 32'hfe2ce6e0, 32'h6fa87e4f,
        32'h85845dd1, 32'hffeff47d, 32'h8f0ccc92, 32'h655b59c3,
        32'hfc93a039, 32'hab9423a7, 32'h432aff97, 32'hf4292244,
        32'hc4ac5665, 32'h1fa27cf8, 32'he6db99e5, 32'hd9d4d039,
        32'h04881d05, 32'hd4ef3085, 32'heaa127fa, 32'h289b7ec6,
        32'hbebfbc70, 32'hf6bb4b60, 32'h4bdecfa9, 32'ha4beea44,
        32'hfde5380c, 32'h6d9d6122, 32'h8771f681, 32'hfffa3942,
        32'h8d2a4c8a, 32'h676f02d9, 32'hfcefa3f8, 32'ha9e3e905,
        32'h455a14ed, 32'hf4d50d87, 32'hc33707d6, 32'h21e1cde6,
        32'he7d3fbc8, 32'hd8a1e681, 32'h02441453, 32'hd62f105d,
        32'he9b6c7aa, 32'h265e5a51, 32'hc040b340, 32'hf61e2562,
        32'h49b40821, 32'ha679438e, 32'hfd987193, 32'h6b901122,
        32'h895cd7be, 32'hffff5bb1, 32'h8b44f7af, 32'h698098d8,
        32'hfd469501, 32'ha8304613, 32'h4787c62a, 32'hf57c0faf,
        32'hc1bdceee, 32'h242070db, 32'he8c7b756, 32'hd76aa478
    };

    localparam logic [15:0][4:0] ROT_AMT = {
        5'd21, 5'd15, 5'd10, 5'd6,
        5'd23, 5'd16, 5'd11, 5'd4,
        5'd20, 5'd14, 5'd9,  5'd5,
        5'd22, 5'd17, 5'd12, 5'd7
    };

    // message word used by a step
    function automatic logic [3:0] msg_idx(input logic [5:0] step);
        logic [7:0] s;
        logic [7:0] g;
        s = {2'b00, step};
        case (step[5:4])
            RND_F:   g = s;
            RND_G:   g = 8'(s * 8'd5 + 8'd1);
            RND_H:   g = 8'(s * 8'd3 + 8'd5);
            RND_I:   g = 8'(s * 8'd7);
            default: g = s;
        endcase
        return g[3:0];
    endfunction

    // rotate left, amount 0 to 31
    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction

endpackage

>>> rtl/md5spd_cell.sv
`timescale 1ns / 1ps

module md5spd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [5:0]          i_step,
    input  logic                i_valid,
    input  md5spd_pkg::t_state  i_state,
    input  md5spd_pkg::t_msg    i_msg,
    output logic                o_valid,
    output md5spd_pkg::t_state  o_state,
    output md5spd_pkg::t_msg    o_msg
);

    logic               r_valid;
    md5spd_pkg::t_state r_state;
    md5spd_pkg::t_msg   r_msg;
    md5spd_pkg::t_state n_state;
    logic [31:0]        w_f;
    logic [31:0]        w_t;

    // round function
    always_comb begin
        case (i_step[5:4])
            md5spd_pkg::RND_F: w_f = (i_state.b & i_state.c) | (~i_state.b & i_state.d);
            md5spd_pkg::RND_G: w_f = (i_state.b & i_state.d) | (i_state.c & ~i_state.d);
            md5spd_pkg::RND_H: w_f = i_state.b ^ i_state.c ^ i_state.d;
            md5spd_pkg::RND_I: w_f = i_state.c ^ (i_state.b | ~i_state.d);
            default:           w_f = i_state.b ^ i_state.c ^ i_state.d;
        endcase
    end

    // one step: sum, rotate, shift the working variables
    assign w_t = i_state.a + w_f + i_msg[md5spd_pkg::msg_idx(i_step)]
               + md5spd_pkg::STEP_K[i_step];

    always_comb begin
        n_state.a = i_state.d;
        n_state.d = i_state.c;
        n_state.c = i_state.b;
        n_state.b = i_state.b
                  + md5spd_pkg::rotl(w_t, md5spd_pkg::ROT_AMT[{i_step[5:4], i_step[1:0]}]);
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload hand-off to the next cell
    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_msg   <= i_msg;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_msg   = r_msg;

endmodule

>>> rtl/md5_short_password_digest.sv
`timescale 1ns / 1ps

// Single-block MD5 of a 0 to 31 byte message. A new item is taken in every
// cycle (busy stays low) and its digest is put on o_result by the chain,
// marked by o_valid for one cycle: 64 step cells in a row, one MD5 step
// each, then one register that adds the initial values back.
// Results cannot be held off, so the receiver must take o_result in the cycle
// o_valid is high. Write password_length through i_cfg_we/i_cfg_wdata only
// while no item is in flight.
module md5_short_password_digest (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  md5spd_pkg::t_in_item   i_block,
    input  logic                   i_cfg_we,
    input  logic [4:0]             i_cfg_wdata,
    output logic                   o_valid,
    output md5spd_pkg::t_out_item  o_result
);

    localparam int N = md5spd_pkg::NUM_STEPS;

    logic [4:0]            r_pwd_len;
    md5spd_pkg::t_msg      w_msg   [0:N];
    md5spd_pkg::t_state    w_state [0:N];
    logic                  w_valid [0:N];
    md5spd_pkg::t_msg      w_raw;
    md5spd_pkg::t_msg      w_pad;
    logic                  r_valid;
    md5spd_pkg::t_out_item r_result;

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwd_len <= 5'd0;
        end else if (i_cfg_we) begin
            r_pwd_len <= i_cfg_wdata;
        end
    end

    // unpack the item into message words
    assign w_raw[1:0]   = i_block.block_words_0_1;
    assign w_raw[3:2]   = i_block.block_words_2_3;
    assign w_raw[5:4]   = i_block.block_words_4_5;
    assign w_raw[7:6]   = i_block.block_words_6_7;
    assign w_raw[9:8]   = i_block.block_words_8_9;
    assign w_raw[11:10] = i_block.block_words_10_11;
    assign w_raw[13:12] = i_block.block_words_12_13;
    assign w_raw[15:14] = '0;

    // pad bit and bit-length word
    always_comb begin
        w_pad = w_raw;
        w_pad[{1'b0, r_pwd_len[4:2]}] = w_raw[{1'b0, r_pwd_len[4:2]}]
            | ({24'd0, md5spd_pkg::PAD_BYTE} << {r_pwd_len[1:0], 3'b000});
        w_pad[14] = {24'd0, r_pwd_len, 3'b000};
    end

    assign w_msg[0]   = w_pad;
    assign w_valid[0] = start;
    assign w_state[0] = {md5spd_pkg::IV_A, md5spd_pkg::IV_B,
                         md5spd_pkg::IV_C, md5spd_pkg::IV_D};

    // chain of step cells
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        md5spd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (6'(gi)),
            .i_valid (w_valid[gi]),
            .i_state (w_state[gi]),
            .i_msg   (w_msg[gi]),
            .o_valid (w_valid[gi+1]),
            .o_state (w_state[gi+1]),
            .o_msg   (w_msg[gi+1])
        );
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_valid[N];
        end
    end

    // add the initial values back
    always_ff @(posedge i_clk) begin
        r_result.digest_ab <= {w_state[N].b + md5spd_pkg::IV_B,
                               w_state[N].a + md5spd_pkg::IV_A};
        r_result.digest_cd <= {w_state[N].d + md5spd_pkg::IV_D,
                               w_state[N].c + md5spd_pkg::IV_C};
    end

    assign busy     = 1'b0;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/md5spd_checker.sv
`timescale 1ns / 1ps

module md5spd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    localparam int LAT = 65;

    // the chain always takes a new item
    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");

    // reset empties the chain
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // every result comes from an item taken a fixed time before
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching item");

    // reset low a fixed time before kills that slot
    a_reset_kills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_rst_n, LAT))
        else $error("result from an item taken in reset");

endmodule

bind md5_short_password_digest md5spd_checker u_md5spd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
